[hw/rtl/hfc_pkg.sv]
package hfc_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int TEMP_W    = 12;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 32;
    localparam int SECONDS_W = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Stream payload widths, padded to whole bytes
    localparam int IN_RAW_W  = TIME_W + TEMP_W + 1 + TEMP_W;
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 3 + TEMP_W + COUNT_W + SECONDS_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FAN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_ENC  = 3'd4;

    // Fan modes
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd2;

    // Die sensor trust window, -40 C to 125 C in sixteenths
    localparam logic signed [TEMP_W-1:0] DIE_MIN = -12'sd640;
    localparam logic signed [TEMP_W-1:0] DIE_MAX = 12'sd2000;

    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for 32-bit x
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
    localparam int PROD_W      = TIME_W + RECIP_W;

    // One poll request
    typedef struct packed {
        logic [TEMP_W-1:0] die_temp;
        logic              enclosure_valid;
        logic [TEMP_W-1:0] enclosure_temp;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

    // One result, packed as on the output stream
    typedef struct packed {
        logic [SECONDS_W-1:0] run_secs;
        logic [COUNT_W-1:0]   transitions;
        logic [TEMP_W-1:0]    last_temp;
        logic                 temp_valid;
        logic                 changed;
        logic                 fan_on;
    } t_result;

    // Decision stage output, run time still in milliseconds
    typedef struct packed {
        logic [TIME_W-1:0]  total_ms;
        logic [COUNT_W-1:0] transitions;
        logic [TEMP_W-1:0]  last_temp;
        logic               temp_valid;
        logic               changed;
        logic               fan_on;
    } t_decision;

endpackage

[hw/rtl/hysteresis_fan_controller.sv]
// Result path: input register, decision register, then seconds register after
// the multiply by 1/1000. Throughput: one poll per cycle unless the output stalls;
// the fan state loop closes in the decision stage.
// Reset: synchronous, active low; clears the fan state, counters and stage
// valids, and loads the default configuration.
module hysteresis_fan_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // fields from bit 0: now_ms[31:0], enclosure_temp[43:32],
    // enclosure_valid[44], die_temp[56:45], zero padding
    input  logic [hfc_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // fields from bit 0: fan_on[0], changed[1], temp_valid[2], last_temp[14:3],
    // transitions[46:15], run_secs[69:47], zero padding
    output logic [hfc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hfc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import hfc_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]        r_mode;
    logic signed [TEMP_W-1:0] r_on_thr;
    logic signed [TEMP_W-1:0] r_off_thr;
    logic [TIME_W-1:0]        r_dwell;
    logic                     r_use_enc;

    // Fan state
    logic                     r_fan;
    logic [TIME_W-1:0]        r_last_change;
    logic [COUNT_W-1:0]       r_count;
    logic [TIME_W-1:0]        r_run_total;
    logic [TIME_W-1:0]        r_run_start;
    logic signed [TEMP_W-1:0] r_held;

    // Pipeline
    logic      r_v0, r_v1, r_v2;
    t_poll     r_in;
    t_decision r_dec;
    t_result   r_out;
    logic      adv0, adv1, adv2, step;

    // Decision logic
    logic signed [TEMP_W-1:0] enc_t, die_t, n_held;
    logic                     enc_pick, die_ok, temp_ok;
    logic                     req, want, dwell_ok, do_change;
    logic [TIME_W-1:0]        since_change, run_elapsed, total_ms;
    t_decision                n_dec;
    logic [PROD_W-1:0]        product;

    assign o_cfg_ready = 1'b1;

    // Stage handshake
    assign adv2 = !r_v2 || i_m_tready;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;
    assign step = r_v0 && adv1;
    assign o_s_tready = adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv0) r_v0 <= i_s_tvalid;
            if (adv1) r_v1 <= r_v0;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (adv0 && i_s_tvalid) r_in <= t_poll'(i_s_tdata[IN_RAW_W-1:0]);
    end

    // Temperature choice
    assign enc_t    = r_in.enclosure_temp;
    assign die_t    = r_in.die_temp;
    assign enc_pick = r_use_enc && r_in.enclosure_valid;
    assign die_ok   = (die_t >= DIE_MIN) && (die_t <= DIE_MAX);
    assign temp_ok  = enc_pick || die_ok;

    always_comb begin
        priority if (enc_pick) n_held = enc_t;
        else if (die_ok)       n_held = die_t;
        else                   n_held = r_held;
    end

    // Wanted fan level per mode
    always_comb begin
        req  = 1'b0;
        want = r_fan;
        unique case (r_mode)
            MODE_OFF: begin
                req  = 1'b1;
                want = 1'b0;
            end
            MODE_ON: begin
                req  = 1'b1;
                want = 1'b1;
            end
            MODE_AUTO: begin
                if (temp_ok) begin
                    priority if (!r_fan && (n_held >= r_on_thr)) begin
                        req  = 1'b1;
                        want = 1'b1;
                    end else if (r_fan && (n_held <= r_off_thr)) begin
                        req  = 1'b1;
                        want = 1'b0;
                    end else begin
                        req  = 1'b0;
                    end
                end
            end
            default: req = 1'b0;
        endcase
    end

    // Dwell check and run time
    assign since_change = r_in.now_ms - r_last_change;
    assign dwell_ok     = since_change >= r_dwell;
    assign do_change    = req && (want != r_fan) && dwell_ok;
    assign run_elapsed  = r_in.now_ms - r_run_start;
    // also the new run total when the fan turns off
    assign total_ms     = r_fan ? r_run_total + run_elapsed : r_run_total;

    always_comb begin
        n_dec.fan_on      = do_change ? want : r_fan;
        n_dec.changed     = do_change;
        n_dec.temp_valid  = temp_ok;
        n_dec.last_temp   = n_held;
        n_dec.transitions = r_count + COUNT_W'(do_change);
        n_dec.total_ms    = total_ms;
    end

    // State update, one poll per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan         <= 1'b0;
            r_last_change <= '0;
            r_count       <= '0;
            r_run_total   <= '0;
            r_run_start   <= '0;
            r_held        <= '0;
        end else if (step) begin
            r_held <= n_held;
            if (do_change) begin
                r_fan         <= want;
                r_last_change <= r_in.now_ms;
                r_count       <= r_count + COUNT_W'(1);
                if (want) r_run_start <= r_in.now_ms;
                else      r_run_total <= total_ms;
            end
        end
    end

    // Decision register
    always_ff @(posedge i_clk) begin
        if (step) r_dec <= n_dec;
    end

    // Milliseconds to whole seconds
    assign product = PROD_W'(r_dec.total_ms) * PROD_W'(RECIP_1000);

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_out.fan_on      <= r_dec.fan_on;
            r_out.changed     <= r_dec.changed;
            r_out.temp_valid  <= r_dec.temp_valid;
            r_out.last_temp   <= r_dec.last_temp;
            r_out.transitions <= r_dec.transitions;
            r_out.run_secs    <= product[RECIP_SHIFT +: SECONDS_W];
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, r_out};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_AUTO;
            r_on_thr  <= 12'sd720;
            r_off_thr <= 12'sd640;
            r_dwell   <= 32'd30000;
            r_use_enc <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FAN_MODE: r_mode    <= i_cfg_data[MODE_W-1:0];
                REG_ON_THR:   r_on_thr  <= i_cfg_data[TEMP_W-1:0];
                REG_OFF_THR:  r_off_thr <= i_cfg_data[TEMP_W-1:0];
                REG_DWELL:    r_dwell   <= i_cfg_data[TIME_W-1:0];
                REG_USE_ENC:  r_use_enc <= i_cfg_data[0];
                default:      r_use_enc <= r_use_enc;
            endcase
        end
    end

endmodule

[hw/rtl/hfc_checker.sv]
module hfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [hfc_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import hfc_pkg::*;

    t_result            res;
    logic               r_prev_fan;
    logic [COUNT_W-1:0] r_prev_count;

    assign res = t_result'(o_m_tdata[OUT_RAW_W-1:0]);

    // Fan level and count of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fan   <= 1'b0;
            r_prev_count <= '0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_prev_fan   <= res.fan_on;
            r_prev_count <= res.transitions;
        end
    end

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result dropped or altered");

    // Changed flag matches a toggle of the fan level
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res.changed == (res.fan_on != r_prev_fan))
        else $error("changed flag disagrees with fan level");

    // Transition count steps by one on each change
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res.transitions == r_prev_count + COUNT_W'(res.changed))
        else $error("transition count out of step");

endmodule

bind hysteresis_fan_controller hfc_checker u_hfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
